/* hw/rtl/rrfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rrfb_pkg;

	// default coordinate width (signed x/y)
	localparam int COORD_WIDTH_DEF = 13;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [31:0] FILL_RESET     = 32'hFF00_0000;
	localparam logic [15:0] SCREEN_W_RESET = 16'd1024;
	localparam logic [15:0] SCREEN_H_RESET = 16'd768;

	// fully opaque alpha byte
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_RECT_WIDTH    = 3'd2,
		REG_RECT_HEIGHT   = 3'd3,
		REG_CORNER_RADIUS = 3'd4,
		REG_FILL_COLOR    = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} cfg_reg_t;

	// coverage decision leaving the geometry pipeline
	typedef struct packed {
		logic valid;
		logic hit;
	} geo_res_t;

endpackage
`default_nettype wire

/* hw/rtl/rrfb_geom.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrfb_geom #(
	parameter int COORD_WIDTH = rrfb_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] pixel_x,
	input  logic signed [COORD_WIDTH-1:0] pixel_y,
	input  logic signed [COORD_WIDTH-1:0] rect_left,
	input  logic signed [COORD_WIDTH-1:0] rect_top,
	input  logic        [COORD_WIDTH-2:0] rect_width,
	input  logic        [COORD_WIDTH-2:0] rect_height,
	input  logic        [COORD_WIDTH-3:0] corner_radius,
	input  logic        [COORD_WIDTH-1:0] screen_width,
	input  logic        [COORD_WIDTH-1:0] screen_height,
	output rrfb_pkg::geo_res_t            res
);
	import rrfb_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int EW   = CW + 2;      // extended signed coordinate
	localparam int RW   = CW - 2;      // radius
	localparam int SQW  = 2 * EW;      // squared distance
	localparam int RSQW = 2 * RW;      // squared radius

	// extended rectangle edges (the user must hold config static while pixels flow; the block does not enforce it)
	logic signed [EW-1:0] rx_e, ry_e, rw_e, rh_e, rx_end, ry_end;
	logic signed [EW-1:0] px_e, py_e;
	logic        [CW-1:0] px_u, py_u;
	logic        [CW-2:0] half_w, half_h;
	logic        [RW-1:0] rad_w, rad_c;
	logic                 on_screen, in_rect, pre_hit;

	assign rx_e   = {{2{rect_left[CW-1]}}, rect_left};
	assign ry_e   = {{2{rect_top[CW-1]}}, rect_top};
	assign rw_e   = {3'b000, rect_width};
	assign rh_e   = {3'b000, rect_height};
	assign rx_end = rx_e + rw_e;
	assign ry_end = ry_e + rh_e;
	assign px_e   = {{2{pixel_x[CW-1]}}, pixel_x};
	assign py_e   = {{2{pixel_y[CW-1]}}, pixel_y};
	assign px_u   = pixel_x;
	assign py_u   = pixel_y;

	// stage 1: clamp radius, screen and rectangle bounds
	always_comb begin
		half_w  = rect_width >> 1;
		half_h  = rect_height >> 1;
		rad_w   = ({1'b0, corner_radius} > half_w) ? half_w[RW-1:0] : corner_radius;
		rad_c   = ({1'b0, rad_w} > half_h) ? half_h[RW-1:0] : rad_w;
		on_screen = !pixel_x[CW-1] && !pixel_y[CW-1] &&
			(px_u < screen_width) && (py_u < screen_height);
		in_rect = (px_e >= rx_e) && (px_e < rx_end) &&
			(py_e >= ry_e) && (py_e < ry_end);
		pre_hit = (rect_width != '0) && (rect_height != '0) && on_screen && in_rect;
	end

	logic                 v_s1, pre_s1;
	logic signed [EW-1:0] px_s1, py_s1;
	logic        [RW-1:0] rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pre_s1 <= pre_hit;
		px_s1  <= px_e;
		py_s1  <= py_e;
		rad_s1 <= rad_c;
	end

	// stage 2: inner band edges
	logic signed [EW-1:0] rad_e;
	logic                 v_s2, pre_s2;
	logic signed [EW-1:0] px_s2, py_s2, xl_s2, xr_s2, yt_s2, yb_s2;
	logic        [RW-1:0] rad_s2;

	assign rad_e = {4'b0000, rad_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pre_s2 <= pre_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		rad_s2 <= rad_s1;
		xl_s2  <= rx_e + rad_e;
		xr_s2  <= rx_end - rad_e;
		yt_s2  <= ry_e + rad_e;
		yb_s2  <= ry_end - rad_e;
	end

	// stage 3: band tests, corner pick, offsets to corner center
	logic                 left_c, right_c, top_c, bot_c;
	logic                 v_s3, pre_s3, band_s3, corner_s3;
	logic signed [EW-1:0] dx_s3, dy_s3;
	logic        [RW-1:0] rad_s3;

	always_comb begin
		left_c  = px_s2 < xl_s2;
		right_c = px_s2 >= xr_s2;
		top_c   = py_s2 < yt_s2;
		bot_c   = py_s2 >= yb_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pre_s3    <= pre_s2;
		band_s3   <= (!left_c && !right_c) || (!top_c && !bot_c);
		corner_s3 <= (left_c || right_c) && (top_c || bot_c);
		dx_s3     <= px_s2 - (left_c ? xl_s2 : xr_s2);
		dy_s3     <= py_s2 - (top_c ? yt_s2 : yb_s2);
		rad_s3    <= rad_s2;
	end

	// stage 4: squares
	logic                  v_s4, pre_s4, band_s4, corner_s4;
	logic signed [SQW-1:0] dx2_s4, dy2_s4;
	logic        [RSQW-1:0] rr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pre_s4    <= pre_s3;
		band_s4   <= band_s3;
		corner_s4 <= corner_s3;
		dx2_s4    <= dx_s3 * dx_s3;
		dy2_s4    <= dy_s3 * dy_s3;
		rr_s4     <= rad_s3 * rad_s3;
	end

	// stage 5: circle compare and final decision
	logic [SQW:0] dist_c, rr_e;
	logic         in_circle;
	geo_res_t     res_s5;

	always_comb begin
		dist_c    = {1'b0, $unsigned(dx2_s4)} + {1'b0, $unsigned(dy2_s4)};
		rr_e      = {{(SQW + 1 - RSQW){1'b0}}, rr_s4};
		in_circle = dist_c <= rr_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s5 <= '0;
		end else begin
			res_s5.valid <= v_s4;
			res_s5.hit   <= v_s4 && pre_s4 && (band_s4 || (corner_s4 && in_circle));
		end
	end

	assign res = res_s5;

endmodule
`default_nettype wire

/* hw/rtl/rrfb_blend.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrfb_blend (
	input  logic        clk,
	input  logic [31:0] bg_pixel,
	input  logic [31:0] fill_color,
	output logic [31:0] color,
	output logic [31:0] bg
);
	import rrfb_pkg::*;

	logic [7:0] alpha, bg_weight;

	assign alpha     = fill_color[31:24];
	assign bg_weight = ALPHA_OPAQUE - alpha;

	// stage 1: capture background
	logic [31:0] bg_s1;

	always_ff @(posedge clk) begin
		bg_s1 <= bg_pixel;
	end

	// stage 2: weighted channel sums, at most 255*255
	logic [15:0] prod_s2 [3];
	logic [31:0] bg_s2;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_s2[c] <= ({8'h00, fill_color[8*c +: 8]} * {8'h00, alpha}) +
				({8'h00, bg_s1[8*c +: 8]} * {8'h00, bg_weight});
		end
		bg_s2 <= bg_s1;
	end

	// stage 3: divide by 255 (exact up to 255*255) and pick the color
	logic [16:0] quo_c [3];
	logic [31:0] color_s3, bg_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quo_c[c] = {1'b0, prod_s2[c]} + {9'h000, prod_s2[c][15:8]} + 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (alpha == '0) begin
			color_s3 <= bg_s2;
		end else if (alpha == ALPHA_OPAQUE) begin
			color_s3 <= fill_color;
		end else begin
			color_s3 <= {ALPHA_OPAQUE, quo_c[2][15:8], quo_c[1][15:8], quo_c[0][15:8]};
		end
		bg_s3 <= bg_s2;
	end

	// stages 4-5: align with the geometry decision
	logic [31:0] color_s4, bg_s4, color_s5, bg_s5;

	always_ff @(posedge clk) begin
		color_s4 <= color_s3;
		bg_s4    <= bg_s3;
		color_s5 <= color_s4;
		bg_s5    <= bg_s4;
	end

	assign color = color_s5;
	assign bg    = bg_s5;

endmodule
`default_nettype wire

/* hw/rtl/rounded_rect_fill_blend.sv */
// Channel   Direction  Handshake           Payload
// request   in         start / busy        pixel_x, pixel_y, bg_pixel
// result    out        done (strobe)       new_pixel, pixel_written
// config    in         cfg_we              cfg_idx, cfg_wdata
//
// One pixel per clock; busy is always low.
// done comes from the last register of the five-stage geometry pipeline
// (clamp/bounds, edges, band/corner, squares, compare), whose first stage loads
// at the accepting edge; the result is valid while done is high.
// Reset clears the valid bits and loads register defaults.
// Results cannot be held off, so nothing in the pipeline ever stalls.
`timescale 1ns / 1ps
`default_nettype none
module rounded_rect_fill_blend #(
	parameter int COORD_WIDTH = rrfb_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       pixel_x,
	input  logic signed [COORD_WIDTH-1:0]       pixel_y,
	input  logic        [31:0]                  bg_pixel,
	output logic                                done,
	output logic        [31:0]                  new_pixel,
	output logic                                pixel_written,
	input  logic                                cfg_we,
	input  logic        [rrfb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic        [rrfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rrfb_pkg::*;

	localparam int CW = COORD_WIDTH;

	// configuration registers
	logic signed [CW-1:0] rect_left_q, rect_top_q;
	logic        [CW-2:0] rect_width_q, rect_height_q;
	logic        [CW-3:0] corner_radius_q;
	logic        [31:0]   fill_color_q;
	logic        [CW-1:0] screen_width_q, screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q     <= '0;
			rect_top_q      <= '0;
			rect_width_q    <= '0;
			rect_height_q   <= '0;
			corner_radius_q <= '0;
			fill_color_q    <= FILL_RESET;
			screen_width_q  <= SCREEN_W_RESET[CW-1:0];
			screen_height_q <= SCREEN_H_RESET[CW-1:0];
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_RECT_LEFT:     rect_left_q     <= cfg_wdata[CW-1:0];
				REG_RECT_TOP:      rect_top_q      <= cfg_wdata[CW-1:0];
				REG_RECT_WIDTH:    rect_width_q    <= cfg_wdata[CW-2:0];
				REG_RECT_HEIGHT:   rect_height_q   <= cfg_wdata[CW-2:0];
				REG_CORNER_RADIUS: corner_radius_q <= cfg_wdata[CW-3:0];
				REG_FILL_COLOR:    fill_color_q    <= cfg_wdata[31:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata[CW-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// coverage pipeline
	geo_res_t geo_res;

	rrfb_geom #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_geom (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.rect_left     (rect_left_q),
		.rect_top      (rect_top_q),
		.rect_width    (rect_width_q),
		.rect_height   (rect_height_q),
		.corner_radius (corner_radius_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.res           (geo_res)
	);

	// color pipeline, same depth
	logic [31:0] blend_color, blend_bg;

	rrfb_blend u_blend (
		.clk        (clk),
		.bg_pixel   (bg_pixel),
		.fill_color (fill_color_q),
		.color      (blend_color),
		.bg         (blend_bg)
	);

	// result select
	assign done          = geo_res.valid;
	assign pixel_written = geo_res.hit;
	assign new_pixel     = geo_res.hit ? blend_color : blend_bg;

endmodule
`default_nettype wire
